@@ rtl/core/i2cm_pkg.sv @@
package i2cm_pkg;

   // command codes, also used as the running operation
   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_WAIT  = 3'd4,
      OP_READ  = 3'd5
   } op_type;

   // phase within one step of a sequence
   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;

   localparam logic [3:0] BITS_PER_BYTE     = 4'd8;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

   // sequencer state carried from tick to tick
   typedef struct packed {
      op_type     op;
      logic [1:0] phase;
      logic [3:0] bit_idx;
      logic [7:0] shift;
      logic [7:0] poll;
      logic       scl;
      logic       sda;
      logic       err;
      logic [7:0] rx_hold;
      logic       ack_hold;
   } state_type;

   // idle sequencer with both lines released
   localparam state_type STATE_RESET = '{
      op:       OP_IDLE,
      phase:    PH_FIRST,
      bit_idx:  4'd0,
      shift:    8'd0,
      poll:     8'd0,
      scl:      1'b1,
      sda:      1'b1,
      err:      1'b0,
      rx_hold:  8'd0,
      ack_hold: 1'b0
   };

endpackage

@@ rtl/core/i2cm_if.sv @@
// request channel: one bus tick with an optional command
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [7:0] tx_byte;
   logic       send_ack;
   logic       sda_sample;

   modport source (output valid, cmd, tx_byte, send_ack, sda_sample, input ready);
   modport sink   (input valid, cmd, tx_byte, send_ack, sda_sample, output ready);
endinterface

// response channel: drive levels and status after one tick
interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_error;

   modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                   ack_error, input ready);
   modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                   ack_error, output ready);
endinterface

@@ rtl/core/i2cm_phase.sv @@
module i2cm_phase
   import i2cm_pkg::*;
(
   input  state_type  state_cur,
   input  logic [2:0] cmd,
   input  logic [7:0] tx_byte,
   input  logic       send_ack,
   input  logic       sda_sample,
   input  logic [7:0] ack_timeout,
   output state_type  state_nxt,
   output logic       done
);

   state_type lat;
   state_type nxt;

   // return to idle at the end of a sequence
   function automatic state_type finish_op(state_type st);
      state_type r;
      r         = st;
      r.op      = OP_IDLE;
      r.phase   = PH_FIRST;
      r.bit_idx = 4'd0;
      return r;
   endfunction

   // one phase of the stop condition
   function automatic state_type stop_step(state_type st);
      state_type r;
      r = st;
      if (st.phase == PH_FIRST) begin
         r.scl   = 1'b0;
         r.sda   = 1'b0;
         r.phase = PH_SECOND;
      end else if (st.phase == PH_SECOND) begin
         r.scl   = 1'b1;
         r.phase = PH_THIRD;
      end else begin
         r.sda = 1'b1;
         r     = finish_op(r);
      end
      return r;
   endfunction

   // latch a new command when idle
   always_comb begin
      lat = state_cur;
      if (state_cur.op == OP_IDLE && cmd >= OP_START && cmd <= OP_READ) begin
         lat.op      = op_type'(cmd);
         lat.phase   = PH_FIRST;
         lat.bit_idx = 4'd0;
         lat.poll    = 8'd0;
         if (cmd == OP_WRITE) begin
            lat.shift = tx_byte;
         end else if (cmd == OP_READ) begin
            lat.shift    = 8'd0;
            lat.ack_hold = send_ack;
         end else if (cmd == OP_WAIT) begin
            lat.err = 1'b0;
         end
      end
   end

   // advance the running sequence by one phase
   always_comb begin
      nxt = lat;
      unique case (lat.op)
         OP_IDLE: begin
         end
         OP_START: begin
            if (lat.phase == PH_FIRST) begin
               nxt.sda   = 1'b1;
               nxt.scl   = 1'b1;
               nxt.phase = PH_SECOND;
            end else if (lat.phase == PH_SECOND) begin
               nxt.sda   = 1'b0;
               nxt.phase = PH_THIRD;
            end else begin
               nxt.scl = 1'b0;
               nxt     = finish_op(nxt);
            end
         end
         OP_STOP: begin
            nxt = stop_step(lat);
         end
         OP_WRITE: begin
            if (lat.phase == PH_FIRST) begin
               nxt.sda   = lat.shift[7];
               nxt.scl   = 1'b1;
               nxt.phase = PH_SECOND;
            end else begin
               nxt.scl     = 1'b0;
               nxt.shift   = {lat.shift[6:0], 1'b0};
               nxt.bit_idx = lat.bit_idx + 4'd1;
               nxt.phase   = PH_FIRST;
               if (nxt.bit_idx >= BITS_PER_BYTE) begin
                  nxt = finish_op(nxt);
               end
            end
         end
         OP_WAIT: begin
            if (lat.phase == PH_FIRST) begin
               nxt.sda   = 1'b1;
               nxt.phase = PH_SECOND;
            end else if (lat.phase == PH_SECOND) begin
               nxt.scl   = 1'b1;
               nxt.phase = PH_THIRD;
            end else if (!sda_sample) begin
               nxt.scl = 1'b0;
               nxt     = finish_op(nxt);
            end else if (lat.poll >= ack_timeout) begin
               // give up: flag the error and run the stop condition
               nxt.err   = 1'b1;
               nxt.op    = OP_STOP;
               nxt.phase = PH_FIRST;
               nxt       = stop_step(nxt);
            end else begin
               nxt.poll = lat.poll + 8'd1;
            end
         end
         OP_READ: begin
            if (lat.bit_idx < BITS_PER_BYTE) begin
               if (lat.phase == PH_FIRST) begin
                  nxt.scl   = 1'b0;
                  nxt.sda   = 1'b1;
                  nxt.phase = PH_SECOND;
               end else begin
                  nxt.scl     = 1'b1;
                  nxt.shift   = {lat.shift[6:0], sda_sample};
                  nxt.bit_idx = lat.bit_idx + 4'd1;
                  nxt.phase   = PH_FIRST;
               end
            end else if (lat.phase == PH_FIRST) begin
               nxt.scl   = 1'b0;
               nxt.sda   = ~lat.ack_hold;
               nxt.phase = PH_SECOND;
            end else if (lat.phase == PH_SECOND) begin
               nxt.scl   = 1'b1;
               nxt.phase = PH_THIRD;
            end else begin
               nxt.scl     = 1'b0;
               nxt.rx_hold = lat.shift;
               nxt         = finish_op(nxt);
            end
         end
         default: begin
            nxt = finish_op(lat);
         end
      endcase
   end

   assign state_nxt = nxt;
   // a sequence completes on the tick that brings it back to idle
   assign done = (lat.op != OP_IDLE) && (nxt.op == OP_IDLE);

endmodule

@@ rtl/core/i2c_master_bit_sequencer.sv @@
// Channel   Dir  Handshake     Payload
// req_chan  in   valid/ready   cmd, tx_byte, send_ack, sda_sample
// rsp_chan  out  valid/ready   scl_level, sda_level, busy_res, done_res, rx_byte, ack_error
// csr       in   csr_wr_en     csr_wr_data (ack_timeout)
//
// Each request transaction is one bus tick and yields one response transaction
// on the next cycle; one tick per cycle is sustained through the response register while responses are taken.
// Request ready drops only while a response waits and rsp_chan.ready is low.
// Synchronous reset releases both lines, idles the sequencer and sets ack_timeout to 250.
module i2c_master_bit_sequencer
   import i2cm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   i2cm_req_if.sink       req_chan,
   i2cm_rsp_if.source     rsp_chan,
   input  logic           csr_wr_en,
   input  logic [7:0]     csr_wr_data
);

   state_type  state_ff;
   state_type  state_in;
   logic       done;
   logic [7:0] timeout_ff;
   logic       rsp_valid_ff;
   logic       scl_ff;
   logic       sda_ff;
   logic       busy_ff;
   logic       done_ff;
   logic [7:0] rx_ff;
   logic       err_ff;
   logic       busy_in;
   logic       accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // hold the acknowledge timeout
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   i2cm_phase u_phase (
      .state_cur   (state_ff),
      .cmd         (req_chan.cmd),
      .tx_byte     (req_chan.tx_byte),
      .send_ack    (req_chan.send_ack),
      .sda_sample  (req_chan.sda_sample),
      .ack_timeout (timeout_ff),
      .state_nxt   (state_in),
      .done        (done)
   );

   // advance sequencer state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // derive response status from the new state
   always_comb begin
      busy_in = (state_in.op != OP_IDLE);
   end

   // hold the response until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         scl_ff  <= state_in.scl;
         sda_ff  <= state_in.sda;
         busy_ff <= busy_in;
         done_ff <= done;
         rx_ff   <= state_in.rx_hold;
         err_ff  <= state_in.err;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.scl_level = scl_ff;
   assign rsp_chan.sda_level = sda_ff;
   assign rsp_chan.busy_res  = busy_ff;
   assign rsp_chan.done_res  = done_ff;
   assign rsp_chan.rx_byte   = rx_ff;
   assign rsp_chan.ack_error = err_ff;

endmodule

@@ rtl/core/i2cm_checker.sv @@
module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl,
   input logic       rsp_sda,
   input logic       rsp_busy,
   input logic       rsp_done,
   input logic [7:0] rsp_rx,
   input logic       rsp_err
);

   // stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scl) && $stable(rsp_sda)
         && $stable(rsp_busy) && $stable(rsp_done) && $stable(rsp_rx) && $stable(rsp_err))
      else $error("response changed while stalled");

   // every accepted tick produces a response
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted tick gave no response");

   // a full response register blocks new ticks
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("tick accepted while response stalled");

   // a completed sequence leaves the sequencer idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done |-> !rsp_busy)
      else $error("done reported while busy");

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_i2cm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_scl   (rsp_chan.scl_level),
   .rsp_sda   (rsp_chan.sda_level),
   .rsp_busy  (rsp_chan.busy_res),
   .rsp_done  (rsp_chan.done_res),
   .rsp_rx    (rsp_chan.rx_byte),
   .rsp_err   (rsp_chan.ack_error)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import i2cm_pkg::*;

   // command codes that start nothing
   localparam logic [2:0] CMD_TICK     = 3'd0;
   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   localparam int IDLE_PCT        = 31;
   localparam int CALM_FIRST      = 1500;
   localparam int CALM_LAST       = 2600;
   localparam int HOLD_OFF_START  = 600;
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int MAX_REPORTS     = 10;
   localparam int END_CYCLES      = 20;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_sample;
   } bus_tick_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rx_byte;
      logic       ack_error;
   } line_state_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   i2cm_req_if req_chan();
   i2cm_rsp_if rsp_chan();

   i2c_master_bit_sequencer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // shadow of the bus sequencer
   op_type     seq_op;
   logic [1:0] seq_phase;
   logic [3:0] seq_bits;
   logic [7:0] seq_shift;
   logic [7:0] seq_polls;
   logic [7:0] seq_rx;
   logic [7:0] ack_limit;
   logic       seq_scl;
   logic       seq_sda;
   logic       seq_err;
   logic       seq_ack;
   int         op_starts [8];
   int         timeouts;

   bus_tick_type   pending_ticks [$];
   line_state_type expected_levels [$];
   bus_tick_type   on_offer;
   line_state_type got_levels;
   line_state_type want_levels;

   int ticks_queued = 0;
   int ticks_taken  = 0;
   int results_seen = 0;
   int mismatches   = 0;
   int cycle_no     = 0;
   int quiet_cycles = 0;
   int hold_left    = 0;

   function automatic logic close_command();
      seq_op    = OP_IDLE;
      seq_phase = PH_FIRST;
      seq_bits  = '0;
      return 1'b1;
   endfunction

   // stop condition: both low, SCL up, then SDA up
   function automatic logic stop_step();
      logic fin;
      fin = 1'b0;
      if (seq_phase == PH_FIRST) begin
         seq_scl   = 1'b0;
         seq_sda   = 1'b0;
         seq_phase = PH_SECOND;
      end else if (seq_phase == PH_SECOND) begin
         seq_scl   = 1'b1;
         seq_phase = PH_THIRD;
      end else begin
         seq_sda = 1'b1;
         fin     = close_command();
      end
      return fin;
   endfunction

   // advance the shadow by one bus tick and return the drive levels after it
   function automatic line_state_type advance_bus(bus_tick_type t);
      line_state_type lv;
      logic           fin;
      fin = 1'b0;
      if (seq_op == OP_IDLE && t.cmd >= OP_START && t.cmd <= OP_READ) begin
         seq_op    = op_type'(t.cmd);
         seq_phase = PH_FIRST;
         seq_bits  = '0;
         seq_polls = '0;
         op_starts[t.cmd]++;
         if (seq_op == OP_WRITE) begin
            seq_shift = t.tx_byte;
         end else if (seq_op == OP_READ) begin
            seq_shift = '0;
            seq_ack   = t.send_ack;
         end else if (seq_op == OP_WAIT) begin
            seq_err = 1'b0;
         end
      end
      case (seq_op)
         OP_START: begin
            if (seq_phase == PH_FIRST) begin
               seq_sda   = 1'b1;
               seq_scl   = 1'b1;
               seq_phase = PH_SECOND;
            end else if (seq_phase == PH_SECOND) begin
               seq_sda   = 1'b0;
               seq_phase = PH_THIRD;
            end else begin
               seq_scl = 1'b0;
               fin     = close_command();
            end
         end
         OP_STOP: begin
            fin = stop_step();
         end
         OP_WRITE: begin
            if (seq_phase == PH_FIRST) begin
               seq_sda   = seq_shift[7];
               seq_scl   = 1'b1;
               seq_phase = PH_SECOND;
            end else begin
               seq_scl   = 1'b0;
               seq_shift = seq_shift << 1;
               seq_bits  = seq_bits + 4'd1;
               seq_phase = PH_FIRST;
               if (seq_bits >= BITS_PER_BYTE) fin = close_command();
            end
         end
         OP_WAIT: begin
            if (seq_phase == PH_FIRST) begin
               seq_sda   = 1'b1;
               seq_phase = PH_SECOND;
            end else if (seq_phase == PH_SECOND) begin
               seq_scl   = 1'b1;
               seq_phase = PH_THIRD;
            end else if (!t.sda_sample) begin
               seq_scl = 1'b0;
               fin     = close_command();
            end else if (seq_polls >= ack_limit) begin
               // give up: flag the error and begin a stop on this tick
               seq_err   = 1'b1;
               timeouts++;
               seq_op    = OP_STOP;
               seq_phase = PH_FIRST;
               fin       = stop_step();
            end else begin
               seq_polls = seq_polls + 8'd1;
            end
         end
         OP_READ: begin
            if (seq_bits < BITS_PER_BYTE) begin
               if (seq_phase == PH_FIRST) begin
                  seq_scl   = 1'b0;
                  seq_sda   = 1'b1;
                  seq_phase = PH_SECOND;
               end else begin
                  seq_scl   = 1'b1;
                  seq_shift = {seq_shift[6:0], t.sda_sample};
                  seq_bits  = seq_bits + 4'd1;
                  seq_phase = PH_FIRST;
               end
            end else if (seq_phase == PH_FIRST) begin
               seq_scl   = 1'b0;
               seq_sda   = !seq_ack;
               seq_phase = PH_SECOND;
            end else if (seq_phase == PH_SECOND) begin
               seq_scl   = 1'b1;
               seq_phase = PH_THIRD;
            end else begin
               seq_scl = 1'b0;
               seq_rx  = seq_shift;
               fin     = close_command();
            end
         end
         default: ;
      endcase
      lv.scl       = seq_scl;
      lv.sda       = seq_sda;
      lv.busy      = (seq_op != OP_IDLE);
      lv.done      = fin;
      lv.rx_byte   = seq_rx;
      lv.ack_error = seq_err;
      return lv;
   endfunction

   function automatic bit take_a_break();
      if (cycle_no >= CALM_FIRST && cycle_no <= CALM_LAST) return 1'b0;
      return $urandom_range(0, 99) < IDLE_PCT;
   endfunction

   // request driver: hold a transaction until accepted, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_levels.push_back(advance_bus(on_offer));
            ticks_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_ticks.size() != 0 && !take_a_break()) begin
               on_offer = pending_ticks.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.cmd        <= on_offer.cmd;
               req_chan.tx_byte    <= on_offer.tx_byte;
               req_chan.send_ack   <= on_offer.send_ack;
               req_chan.sda_sample <= on_offer.sda_sample;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: compare each transaction with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_levels = '{rsp_chan.scl_level, rsp_chan.sda_level, rsp_chan.busy_res,
                           rsp_chan.done_res, rsp_chan.rx_byte, rsp_chan.ack_error};
            results_seen++;
            if (expected_levels.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("response %0d arrived with no tick pending: scl %b sda %b",
                           results_seen, got_levels.scl, got_levels.sda);
            end else begin
               want_levels = expected_levels.pop_front();
               if (got_levels !== want_levels) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("response %0d expected: scl %b sda %b busy %b done %b rx %h err %b",
                              results_seen, want_levels.scl, want_levels.sda,
                              want_levels.busy, want_levels.done, want_levels.rx_byte,
                              want_levels.ack_error);
                     $display("response %0d actual:   scl %b sda %b busy %b done %b rx %h err %b",
                              results_seen, got_levels.scl, got_levels.sda,
                              got_levels.busy, got_levels.done, got_levels.rx_byte,
                              got_levels.ack_error);
                  end
               end
            end
         end
         // hold off once for a long stretch so the block backs up
         if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (cycle_no == HOLD_OFF_START) begin
            hold_left      <= HOLD_OFF_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !take_a_break();
         end
      end
   end

   // watchdog: end the run if no transaction moves for too long
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_tick(input logic [2:0] cmd, input logic [7:0] tx,
                             input logic ack, input logic sda);
      pending_ticks.push_back('{cmd, tx, ack, sda});
      ticks_queued++;
   endtask

   // tick while a command runs; now and then offer a command that must be ignored
   task automatic queue_filler(input logic sda);
      logic [2:0] cmd;
      cmd = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : CMD_TICK;
      queue_tick(cmd, 8'($urandom), 1'($urandom), sda);
   endtask

   task automatic queue_busy(input int n);
      repeat (n) queue_filler(1'($urandom));
   endtask

   task automatic start_cond();
      queue_tick(OP_START, 8'($urandom), 1'($urandom), 1'($urandom));
      queue_busy(2);
   endtask

   task automatic stop_cond();
      queue_tick(OP_STOP, 8'($urandom), 1'($urandom), 1'($urandom));
      queue_busy(2);
   endtask

   task automatic send_byte(input logic [7:0] b);
      queue_tick(OP_WRITE, b, 1'($urandom), 1'($urandom));
      queue_busy(15);
   endtask

   task automatic fetch_byte(input logic ack);
      queue_tick(OP_READ, 8'($urandom), ack, 1'($urandom));
      queue_busy(18);
   endtask

   // wait for acknowledge: either pulled low after a few polls or never
   task automatic poll_ack(input bit acked);
      int hi;
      hi = (ack_limit < 6) ? int'(ack_limit) : 6;
      queue_tick(OP_WAIT, 8'($urandom), 1'($urandom), 1'($urandom));
      queue_busy(1);
      if (acked) begin
         repeat ($urandom_range(0, hi)) queue_filler(1'b1);
         queue_filler(1'b0);
      end else begin
         repeat (int'(ack_limit) + 1) queue_filler(1'b1);
         queue_busy(2);
      end
   endtask

   task automatic bus_gap();
      int r;
      repeat ($urandom_range(0, 3)) begin
         r = $urandom_range(0, 5);
         queue_tick((r == 0) ? CMD_SPARE_LO : (r == 1) ? CMD_SPARE_HI : CMD_TICK,
                    8'($urandom), 1'($urandom), 1'($urandom));
      end
   endtask

   function automatic bit pick_ack();
      if (ack_limit > 20) return $urandom_range(0, 49) != 0;
      return $urandom_range(0, 3) != 0;
   endfunction

   // well-formed transfer: start, bytes with acknowledge, optional read-back, stop
   task automatic transfer();
      logic [7:0] b;
      start_cond();
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else b = 8'($urandom);
         send_byte(b);
         poll_ack(pick_ack());
      end
      if ($urandom_range(0, 2) == 0) begin
         start_cond();
         send_byte(8'($urandom));
         poll_ack(pick_ack());
         repeat ($urandom_range(1, 2)) fetch_byte(1'($urandom));
      end
      stop_cond();
      bus_gap();
   endtask

   task automatic random_phase(input int goal);
      int stop_at;
      stop_at = ticks_queued + goal;
      while (ticks_queued < stop_at) begin
         if ($urandom_range(0, 99) < 85) begin
            transfer();
         end else begin
            repeat ($urandom_range(1, 12))
               queue_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                          1'($urandom));
         end
      end
   endtask

   // drain everything, then tick until the sequencer is back to idle
   task automatic settle();
      bit running;
      running = 1'b1;
      while (running) begin
         do @(negedge clock);
         while (pending_ticks.size() != 0 || ticks_taken != ticks_queued ||
                expected_levels.size() != 0);
         if (seq_op == OP_IDLE) running = 1'b0;
         else queue_tick(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
      end
   endtask

   task automatic set_ack_timeout(input logic [7:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ack_limit = v;
      @(negedge clock);
   endtask

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = CMD_TICK;
      req_chan.tx_byte    = '0;
      req_chan.send_ack   = 1'b0;
      req_chan.sda_sample = 1'b1;
      rsp_chan.ready      = 1'b0;
      seq_op    = OP_IDLE;
      seq_phase = PH_FIRST;
      seq_bits  = '0;
      seq_shift = '0;
      seq_polls = '0;
      seq_rx    = '0;
      seq_scl   = 1'b1;
      seq_sda   = 1'b1;
      seq_err   = 1'b0;
      seq_ack   = 1'b0;
      ack_limit = ACK_TIMEOUT_RESET;
      timeouts  = 0;
      foreach (op_starts[i]) op_starts[i] = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // idle ticks hold the lines, spare codes do nothing
      queue_tick(CMD_TICK, 8'h00, 1'b0, 1'b1);
      queue_tick(CMD_SPARE_LO, 8'hFF, 1'b1, 1'b0);
      queue_tick(CMD_SPARE_HI, 8'h5A, 1'b0, 1'b1);
      // start with a write offered in the middle, which is dropped
      queue_tick(OP_START, 8'h00, 1'b0, 1'b1);
      queue_tick(OP_WRITE, 8'hA5, 1'b1, 1'b1);
      queue_tick(CMD_TICK, 8'h00, 1'b0, 1'b0);
      // acknowledge seen on the first poll
      queue_tick(OP_WAIT, 8'h00, 1'b0, 1'b1);
      queue_tick(CMD_TICK, 8'h00, 1'b0, 1'b1);
      queue_tick(CMD_TICK, 8'h00, 1'b0, 1'b0);
      stop_cond();
      random_phase(180);
      settle();

      // zero timeout: the first high poll already gives up
      set_ack_timeout(8'd0);
      poll_ack(1'b0);
      random_phase(200);
      settle();

      // longest timeout, run out once in full
      set_ack_timeout(8'd255);
      poll_ack(1'b0);
      random_phase(100);
      settle();

      repeat (3) begin
         set_ack_timeout(8'($urandom_range(1, 12)));
         random_phase(200);
         settle();
      end

      set_ack_timeout(8'($urandom_range(13, 254)));
      random_phase(150);
      settle();

      repeat (END_CYCLES) @(posedge clock);
      $display("covered %0d ticks, %0d responses, ack_timeout 250, 0, 255 and mixed",
               ticks_taken, results_seen);
      $display("runs: %0d start, %0d stop, %0d write, %0d wait-ack (%0d timeouts), %0d read",
               op_starts[OP_START], op_starts[OP_STOP], op_starts[OP_WRITE],
               op_starts[OP_WAIT], timeouts, op_starts[OP_READ]);
      if (mismatches == 0 && expected_levels.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_if.sv
rtl/core/i2cm_phase.sv
rtl/core/i2c_master_bit_sequencer.sv
rtl/core/i2cm_checker.sv
sim/tb_top.sv
